[hdl/fspq_pkg.sv]
// Shared types, constants and lookup functions for the fixed-sum probability quantizer.
// No dependencies.
package fspq_pkg;

    localparam int NUM_LANES = 8;
    localparam int IN_W      = 24;
    localparam int P_W       = IN_W - 1;
    localparam int CNT_W     = 4;
    localparam int Q_W       = 16;
    localparam int NUM_W     = P_W + Q_W;
    localparam int SUM_W     = P_W + $clog2(NUM_LANES);
    localparam int DIV_W     = SUM_W + Q_W;
    localparam int ACC_W     = Q_W + $clog2(NUM_LANES);
    localparam int LANE_LAT  = Q_W + 1;
    localparam int IDX_W     = $clog2(NUM_LANES);
    localparam logic [Q_W-1:0] QSUM = 16'hFFFF;

    typedef logic [Q_W-1:0]   quant_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic             uniform;
        logic [CNT_W-1:0] count;
    } fspq_ctl_t;

    // even split of QSUM over n lanes
    function automatic quant_t uniform_share(input logic [CNT_W-1:0] n);
        quant_t s;
        begin
            unique case (n)
                4'd1: s = 16'd65535;
                4'd2: s = 16'd32767;
                4'd3: s = 16'd21845;
                4'd4: s = 16'd16383;
                4'd5: s = 16'd13107;
                4'd6: s = 16'd10922;
                4'd7: s = 16'd9362;
                4'd8: s = 16'd8191;
                default: s = 16'd65535;
            endcase
            return s;
        end
    endfunction

    // remainder of that split, added to lane 0
    function automatic quant_t uniform_extra(input logic [CNT_W-1:0] n);
        quant_t e;
        begin
            unique case (n)
                4'd2: e = 16'd1;
                4'd4: e = 16'd3;
                4'd6: e = 16'd3;
                4'd7: e = 16'd1;
                4'd8: e = 16'd7;
                default: e = 16'd0;
            endcase
            return e;
        end
    endfunction

endpackage

[hdl/fspq_lane.sv]
// One lane: pipelined restoring divider, one quotient bit per stage, then round half up.
// Depends on fspq_pkg.
module fspq_lane (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [fspq_pkg::NUM_W-1:0] num_in,
    input  logic [fspq_pkg::SUM_W-1:0] den_in,
    output logic [fspq_pkg::Q_W-1:0]   r_out,
    output logic [fspq_pkg::SUM_W-1:0] rem_out
);
    import fspq_pkg::*;

    logic [DIV_W-1:0] rem_reg [Q_W];
    logic [SUM_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [Q_W-1:0]   r_reg;
    logic [SUM_W-1:0] rfin_reg;

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic [DIV_W-1:0] rem_cur;
            logic [SUM_W-1:0] den_cur;
            logic [Q_W-1:0]   quo_cur;
            logic [DIV_W-1:0] dsh;
            logic             ge;
            if (k == 0) begin : g_first
                assign rem_cur = DIV_W'(num_in);
                assign den_cur = den_in;
                assign quo_cur = '0;
            end else begin : g_next
                assign rem_cur = rem_reg[k-1];
                assign den_cur = den_reg[k-1];
                assign quo_cur = quo_reg[k-1];
            end
            assign dsh = DIV_W'(den_cur) << (Q_W - 1 - k);
            assign ge  = (rem_cur >= dsh);
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? (rem_cur - dsh) : rem_cur;
                    den_reg[k] <= den_cur;
                    quo_reg[k] <= {quo_cur[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    logic [SUM_W-1:0] rem_fin;
    logic [SUM_W:0]   rem_dbl;
    logic [Q_W-1:0]   quo_fin;
    logic             up;
    assign rem_fin = rem_reg[Q_W-1][SUM_W-1:0];
    assign quo_fin = quo_reg[Q_W-1];
    assign rem_dbl = {rem_fin, 1'b0};
    assign up      = (rem_dbl >= {1'b0, den_reg[Q_W-1]}) && !(&quo_fin);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= quo_fin + Q_W'(up);
            rfin_reg <= rem_fin;
        end
    end

    assign r_out   = r_reg;
    assign rem_out = rfin_reg;

endmodule

[hdl/fspq_merge.sv]
// Merge stage: lane total and largest-remainder pick (registered), then correction.
// Depends on fspq_pkg.
module fspq_merge (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [fspq_pkg::Q_W-1:0]   r_in   [fspq_pkg::NUM_LANES],
    input  logic [fspq_pkg::SUM_W-1:0] rem_in [fspq_pkg::NUM_LANES],
    input  fspq_pkg::fspq_ctl_t        ctl_in,
    output logic [fspq_pkg::Q_W-1:0]   quant_out [fspq_pkg::NUM_LANES],
    output logic                       uniform_out
);
    import fspq_pkg::*;

    quant_t           q_reg [NUM_LANES];
    logic [ACC_W-1:0] acc_reg;
    logic [IDX_W-1:0] best_reg;
    fspq_ctl_t        ctl_reg;

    logic [ACC_W-1:0] acc_next;
    logic [IDX_W-1:0] best_next;
    sum_t             best_rem;

    always_comb begin
        acc_next  = '0;
        best_next = '0;
        best_rem  = rem_in[0];
        for (int i = 0; i < NUM_LANES; i++) begin
            if (CNT_W'(i) < ctl_in.count) begin
                acc_next = acc_next + ACC_W'(r_in[i]);
                if (i > 0 && rem_in[i] > best_rem) begin
                    best_rem  = rem_in[i];
                    best_next = IDX_W'(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                q_reg[i] <= r_in[i];
            end
            acc_reg  <= acc_next;
            best_reg <= best_next;
            ctl_reg  <= ctl_in;
        end
    end

    logic [ACC_W+1:0] fix;
    quant_t           fixed_q;
    quant_t           share;

    assign fix   = (ACC_W+2)'(q_reg[best_reg]) + (ACC_W+2)'(QSUM) - (ACC_W+2)'(acc_reg);
    assign share = uniform_share(ctl_reg.count);

    always_comb begin
        priority if (fix[ACC_W+1])                 fixed_q = '0;
        else if (fix > (ACC_W+2)'(QSUM))           fixed_q = QSUM;
        else                                       fixed_q = fix[Q_W-1:0];
    end

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (CNT_W'(i) >= ctl_reg.count) begin
                quant_out[i] = '0;
            end else if (ctl_reg.uniform) begin
                quant_out[i] = (i == 0) ? share + uniform_extra(ctl_reg.count) : share;
            end else if (IDX_W'(i) == best_reg) begin
                quant_out[i] = fixed_q;
            end else begin
                quant_out[i] = q_reg[i];
            end
        end
    end

    assign uniform_out = ctl_reg.uniform;

endmodule

[hdl/fixed_sum_probability_quantizer.sv]
// Fixed-sum probability quantizer, top level.
// Depends on fspq_pkg, fspq_lane, fspq_merge.
//
// Usage:
//   Input channel s_*: eight signed lane probabilities and an active count.
//   Result channel m_*: eight unsigned 16-bit shares that add up to 65535 over
//   the active lanes, plus a flag set when the even split was used.
//   Throughput: one item per cycle while no stall holds; each lane has its own 16-stage
//   divider, one quotient bit per stage, so a new column enters every unstalled cycle.
//   Stall: when m_valid is high and m_ready low, the whole pipeline holds and
//   s_ready drops; items already inside are kept, none are dropped.
//   Reset (aresetn low, synchronous): all stage valid bits and m_valid clear;
//   payload registers are not reset. s_ready is low while aresetn is low.
//   Count: 0 counts as one lane, above eight as eight; negative lanes as zero.
module fixed_sum_probability_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [23:0] s_prob_0,
    input  logic signed [23:0] s_prob_1,
    input  logic signed [23:0] s_prob_2,
    input  logic signed [23:0] s_prob_3,
    input  logic signed [23:0] s_prob_4,
    input  logic signed [23:0] s_prob_5,
    input  logic signed [23:0] s_prob_6,
    input  logic signed [23:0] s_prob_7,
    input  logic [3:0]  s_action_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_quant_0,
    output logic [15:0] m_quant_1,
    output logic [15:0] m_quant_2,
    output logic [15:0] m_quant_3,
    output logic [15:0] m_quant_4,
    output logic [15:0] m_quant_5,
    output logic [15:0] m_quant_6,
    output logic [15:0] m_quant_7,
    output logic        m_uniform_used
);
    import fspq_pkg::*;

    localparam int VLD_N = LANE_LAT + 2;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en && aresetn;

    logic [IN_W-1:0]  prob_in [NUM_LANES];
    assign prob_in[0] = s_prob_0;
    assign prob_in[1] = s_prob_1;
    assign prob_in[2] = s_prob_2;
    assign prob_in[3] = s_prob_3;
    assign prob_in[4] = s_prob_4;
    assign prob_in[5] = s_prob_5;
    assign prob_in[6] = s_prob_6;
    assign prob_in[7] = s_prob_7;

    // front stage: clamp, mask, sum, scale
    logic [CNT_W-1:0] cnt;
    logic [P_W-1:0]   p     [NUM_LANES];
    sum_t             sum_next;

    always_comb begin
        priority if (s_action_count == '0)                   cnt = CNT_W'(1);
        else if (s_action_count > CNT_W'(NUM_LANES))         cnt = CNT_W'(NUM_LANES);
        else                                                 cnt = s_action_count;
        sum_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (prob_in[i][IN_W-1] || CNT_W'(i) >= cnt) p[i] = '0;
            else                                       p[i] = prob_in[i][P_W-1:0];
            sum_next = sum_next + SUM_W'(p[i]);
        end
    end

    logic [NUM_W-1:0] num_reg [NUM_LANES];
    sum_t             sum_reg;
    fspq_ctl_t        ctl_reg [LANE_LAT+1];
    logic             vld_reg [VLD_N];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                num_reg[i] <= {p[i], Q_W'(0)} - NUM_W'(p[i]);
            end
            sum_reg            <= sum_next;
            ctl_reg[0].uniform <= (sum_next == '0);
            ctl_reg[0].count   <= cnt;
            for (int k = 1; k <= LANE_LAT; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VLD_N; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < VLD_N; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    quant_t r      [NUM_LANES];
    sum_t   rem    [NUM_LANES];

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            fspq_lane u_lane (
                .aclk    (aclk),
                .en      (en),
                .num_in  (num_reg[g]),
                .den_in  (sum_reg),
                .r_out   (r[g]),
                .rem_out (rem[g])
            );
        end
    endgenerate

    quant_t quant   [NUM_LANES];
    logic   uniform;

    fspq_merge u_merge (
        .aclk        (aclk),
        .en          (en),
        .r_in        (r),
        .rem_in      (rem),
        .ctl_in      (ctl_reg[LANE_LAT]),
        .quant_out   (quant),
        .uniform_out (uniform)
    );

    quant_t out_reg [NUM_LANES];
    logic   uni_reg;
    logic   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) out_reg[i] <= quant[i];
            uni_reg <= uniform;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_quant_0      = out_reg[0];
    assign m_quant_1      = out_reg[1];
    assign m_quant_2      = out_reg[2];
    assign m_quant_3      = out_reg[3];
    assign m_quant_4      = out_reg[4];
    assign m_quant_5      = out_reg[5];
    assign m_quant_6      = out_reg[6];
    assign m_quant_7      = out_reg[7];
    assign m_uniform_used = uni_reg;

    logic [ACC_W-1:0] out_total;
    always_comb begin
        out_total = '0;
        for (int i = 0; i < NUM_LANES; i++) out_total = out_total + ACC_W'(out_reg[i]);
    end

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_uniform_used |-> out_total == ACC_W'(QSUM))
        else $error("even split does not add up to full scale");

    a_uniform_lane0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_uniform_used |-> m_quant_0 >= m_quant_1)
        else $error("even split gave lane 0 less than lane 1");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting item");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg[VLD_N-1]))
        else $error("pipeline moved during a stall");

endmodule
